// ----- hw/rtl/usbpd_pkg.sv -----
// usbpd_pkg: shared types, constants and 4b5b tables for the bmc receiver
// depends on nothing; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none
package usbpd_pkg;

  localparam int MaxSymbolsDefault   = 132;
  localparam int PayloadBytesDefault = 64;

  // configuration register indexes
  localparam logic [1:0] CFG_SHORT_LIMIT = 2'd0;
  localparam logic [1:0] CFG_LONG_LIMIT  = 2'd1;
  localparam logic [1:0] CFG_ACK_MASK    = 2'd2;

  // decoded symbol codes
  localparam logic [4:0] K_S1  = 5'd16;
  localparam logic [4:0] K_S2  = 5'd17;
  localparam logic [4:0] K_S3  = 5'd18;
  localparam logic [4:0] K_R1  = 5'd19;
  localparam logic [4:0] K_R2  = 5'd20;
  localparam logic [4:0] K_EOP = 5'd21;
  localparam logic [4:0] K_BAD = 5'd22;

  localparam logic [31:0] CRC_RESIDUE = 32'hDEBB20E3;
  localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
  localparam logic [4:0]  MTYPE_GOODCRC = 5'h01;

  localparam int NumTargets = 7;

  // event handed from front to back
  typedef enum logic {
    EV_BYTE = 1'b0,
    EV_EOP  = 1'b1
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t   kind;
    logic       first;   // first event since the frame state was cleared
    logic [7:0] data;
    logic [2:0] target;
  } ev_t;

  // 4b5b line code to symbol
  function automatic logic [4:0] sym_decode(input logic [4:0] code);
    logic [4:0] s;
    unique case (code)
      5'd6:  s = K_S3;
      5'd7:  s = K_R1;
      5'd9:  s = 5'd1;
      5'd10: s = 5'd4;
      5'd11: s = 5'd5;
      5'd13: s = K_EOP;
      5'd14: s = 5'd6;
      5'd15: s = 5'd7;
      5'd17: s = K_S2;
      5'd18: s = 5'd8;
      5'd19: s = 5'd9;
      5'd20: s = 5'd2;
      5'd21: s = 5'd3;
      5'd22: s = 5'd10;
      5'd23: s = 5'd11;
      5'd24: s = K_S1;
      5'd25: s = K_R2;
      5'd26: s = 5'd12;
      5'd27: s = 5'd13;
      5'd28: s = 5'd14;
      5'd29: s = 5'd15;
      5'd30: s = 5'd0;
      default: s = K_BAD;
    endcase
    return s;
  endfunction

  function automatic logic [19:0] oset(input logic [4:0] a, input logic [4:0] b,
                                       input logic [4:0] c, input logic [4:0] d);
    return {d, c, b, a};
  endfunction

  // ordered set of each target
  function automatic logic [19:0] target_set(input int t);
    logic [19:0] v;
    unique case (t)
      0: v = oset(K_S1, K_S1, K_S1, K_S2);
      1: v = oset(K_S1, K_S1, K_S3, K_S3);
      2: v = oset(K_S1, K_S3, K_S1, K_S3);
      3: v = oset(K_S1, K_R2, K_R2, K_S3);
      4: v = oset(K_S1, K_R2, K_S3, K_S2);
      5: v = oset(K_R1, K_R1, K_R1, K_R2);
      default: v = oset(K_R1, K_S1, K_R1, K_S3);
    endcase
    return v;
  endfunction

  // reflected crc-32 over one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/usb_pd_bmc_receiver.sv -----
// usb_pd_bmc_receiver: top level of the bmc / 4b5b receiver
// depends on usbpd_pkg, usbpd_front, usbpd_evq, usbpd_back
//
// channel  | handshake          | beat contents
// ---------+--------------------+-----------------------------------------
// input    | push / full        | pulse_length
// config   | cfg_valid/cfg_ready| cfg_index, cfg_data
// result   | empty / pop        | item_kind .. ack_message_id
//
// one pulse per clock is accepted while full is low; the front decodes it in
// the cycle it is taken and writes any event into the two-entry event queue at
// that edge; the back moves it into the result register once that register
// is empty or being popped.
// rst clears frame state, queue and result register; config takes defaults.
// full rises only when the queue is full while the result is not popped.
// cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none
module usb_pd_bmc_receiver
  import usbpd_pkg::*;
#(
  parameter int MAX_SYMBOLS   = MaxSymbolsDefault,
  parameter int PAYLOAD_BYTES = PayloadBytesDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [14:0] pulse_length,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  output logic             empty,
  input  wire logic        pop,
  output logic             item_kind,
  output logic [7:0]       payload_byte,
  output logic [2:0]       frame_target,
  output logic             crc_good,
  output logic [6:0]       frame_bytes,
  output logic             ack_request,
  output logic [2:0]       ack_message_id
);

  logic [7:0] short_limit;
  logic [7:0] long_limit;
  logic [6:0] ack_target_mask;

  logic take;
  ev_t  f_ev, q_ev;
  logic f_ev_valid, q_valid, q_take, q_full;

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign take      = push && !q_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      short_limit     <= 8'd16;
      long_limit      <= 8'd24;
      ack_target_mask <= 7'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SHORT_LIMIT: short_limit     <= cfg_data;
        CFG_LONG_LIMIT:  long_limit      <= cfg_data;
        CFG_ACK_MASK:    ack_target_mask <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  usbpd_front #(.MAX_SYMBOLS(MAX_SYMBOLS)) u_front (
    .clk, .rst, .take, .pulse_length, .short_limit, .long_limit,
    .ev(f_ev), .ev_valid(f_ev_valid)
  );

  usbpd_evq u_evq (
    .clk, .rst, .wr(take && f_ev_valid), .wr_data(f_ev),
    .rd(q_take), .rd_data(q_ev), .rd_valid(q_valid), .q_full
  );

  usbpd_back #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_back (
    .clk, .rst, .ev(q_ev), .ev_valid(q_valid), .ev_take(q_take),
    .ack_target_mask, .pop, .empty, .item_kind, .payload_byte, .frame_target,
    .crc_good, .frame_bytes, .ack_request, .ack_message_id
  );

endmodule
`default_nettype wire

// ----- hw/rtl/usbpd_front.sv -----
// usbpd_front: pulse classification, bmc bits, 4b5b symbols and frame phase
// depends on usbpd_pkg; emits byte and end-of-packet events
`timescale 1ns / 1ps
`default_nettype none
module usbpd_front
  import usbpd_pkg::*;
#(
  parameter int MAX_SYMBOLS = MaxSymbolsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        take,
  input  wire logic [14:0] pulse_length,
  input  wire logic [7:0]  short_limit,
  input  wire logic [7:0]  long_limit,
  output ev_t              ev,
  output logic             ev_valid
);

  typedef enum logic [1:0] {
    PH_INIT, PH_PREAMBLE, PH_SOP, PH_PAYLOAD
  } phase_t;

  localparam logic [7:0] MaxSym = 8'(MAX_SYMBOLS);

  phase_t             phase, phase_next;
  logic               short_pending, short_pending_next;
  logic signed [8:0]  adjust, adjust_next;
  logic [4:0]         window, window_next;
  logic [2:0]         bit_cnt, bit_cnt_next;
  logic [7:0]         sym_cnt, sym_cnt_next;
  logic [19:0]        oset_reg, oset_next;
  logic [4:0]         low_nib, low_nib_next;
  logic [2:0]         target, target_next;
  logic               first, first_next;

  // combinational step for one pulse
  always_comb begin
    logic signed [16:0] dur;
    logic signed [16:0] thr;
    logic               is_long;
    logic               push_b;
    logic               bit_v;
    logic [4:0]         sym;
    logic [7:0]         idx;
    logic [7:0]         pair;
    phase_t             ph;

    phase_next         = phase;
    short_pending_next = short_pending;
    adjust_next        = adjust;
    window_next        = window;
    bit_cnt_next       = bit_cnt;
    sym_cnt_next       = sym_cnt;
    oset_next          = oset_reg;
    low_nib_next       = low_nib;
    target_next        = target;
    first_next         = first;
    ev_valid           = 1'b0;
    ev.kind            = EV_BYTE;
    ev.first           = first;
    ev.data            = 8'd0;
    ev.target          = target;
    push_b = 1'b0;
    bit_v  = 1'b0;
    sym    = 5'd0;
    idx    = sym_cnt;
    pair   = 8'd0;
    ph     = phase;
    dur    = {2'b00, pulse_length};
    thr    = 17'sd0;
    is_long = 1'b0;

    if (pulse_length == 15'd0) begin
      phase_next = PH_INIT;
    end else begin
      // a new frame starts from cleared state
      if (phase == PH_INIT) begin
        ph                 = PH_PREAMBLE;
        short_pending_next = 1'b0;
        adjust_next        = 9'sd0;
        window_next        = 5'd0;
        bit_cnt_next       = 3'd0;
        sym_cnt_next       = 8'd0;
        oset_next          = 20'd0;
        low_nib_next       = 5'd0;
        target_next        = 3'd0;
        first_next         = 1'b1;
      end
      // long or short against the adjusted threshold
      thr = $signed({9'd0, long_limit}) + 17'(adjust_next);
      is_long = dur > thr;
      if (!is_long && dur > $signed({9'd0, short_limit}))
        adjust_next = 9'($signed({9'd0, short_limit}) - dur);
      else
        adjust_next = 9'sd0;
      // bmc bit recovery
      if (short_pending_next) begin
        short_pending_next = 1'b0;
        if (is_long) ph = PH_INIT;
        else begin
          push_b = 1'b1;
          bit_v  = 1'b1;
        end
      end else begin
        if (is_long) push_b = 1'b1;
        else short_pending_next = 1'b1;
      end
      if (push_b) begin
        window_next  = {bit_v, window_next[4:1]};
        bit_cnt_next = bit_cnt_next + 3'd1;
      end
      sym = sym_decode(window_next);
      // preamble hunt
      if (ph == PH_PREAMBLE && (sym == K_S1 || sym == K_R1)) begin
        ph           = PH_SOP;
        bit_cnt_next = 3'd5;
      end
      if (ph == PH_SOP && bit_cnt_next == 3'd5) begin
        // ordered set collection
        bit_cnt_next = 3'd0;
        unique case (sym_cnt_next[1:0])
          2'd0: oset_next = oset_next | {15'd0, sym};
          2'd1: oset_next = oset_next | {10'd0, sym, 5'd0};
          2'd2: oset_next = oset_next | {5'd0, sym, 10'd0};
          default: oset_next = oset_next | {sym, 15'd0};
        endcase
        sym_cnt_next = sym_cnt_next + 8'd1;
        if (sym_cnt_next >= 8'd4) begin
          ph = PH_INIT;
          for (int j = 0; j < NumTargets; j++) begin
            if (oset_next == target_set(j)) begin
              target_next = 3'(j);
              ph          = PH_PAYLOAD;
            end
          end
        end
      end else if (ph == PH_PAYLOAD && bit_cnt_next == 3'd5) begin
        // payload symbol pairing
        bit_cnt_next = 3'd0;
        idx = sym_cnt_next;
        if (idx < MaxSym) begin
          sym_cnt_next = idx + 8'd1;
          if (!idx[0]) begin
            low_nib_next = {1'b1, sym[3:0]};
          end else begin
            pair = {sym[3:0], low_nib_next[3:0]};
            if (low_nib_next[4] && sym != K_EOP && (idx + 8'd1) < MaxSym) begin
              ev_valid = 1'b1;
              ev.kind  = EV_BYTE;
              ev.data  = pair;
            end
            low_nib_next = 5'd0;
          end
        end
        if (!ev_valid && sym == K_EOP) begin
          ev_valid = 1'b1;
          ev.kind  = EV_EOP;
          ph       = PH_INIT;
        end
      end
      ev.first   = first_next;
      ev.target  = target_next;
      phase_next = ph;
      if (ev_valid) first_next = 1'b0;
    end
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_INIT;
      short_pending <= 1'b0;
      adjust        <= 9'sd0;
      window        <= 5'd0;
      bit_cnt       <= 3'd0;
      sym_cnt       <= 8'd0;
      oset_reg      <= 20'd0;
      low_nib       <= 5'd0;
      target        <= 3'd0;
      first         <= 1'b1;
    end else if (take) begin
      phase         <= phase_next;
      short_pending <= short_pending_next;
      adjust        <= adjust_next;
      window        <= window_next;
      bit_cnt       <= bit_cnt_next;
      sym_cnt       <= sym_cnt_next;
      oset_reg      <= oset_next;
      low_nib       <= low_nib_next;
      target        <= target_next;
      first         <= first_next;
    end
  end

  // an event always follows a completed bit, so no half bit is left open
  a_event_no_pending: assert property (@(posedge clk) disable iff (rst)
    (take && ev_valid) |=> !short_pending)
    else $error("event emitted with a half bit pending");

  // payload phase needs a matched target
  a_target_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (target < 3'(NumTargets)))
    else $error("target index out of range in payload");

endmodule
`default_nettype wire

// ----- hw/rtl/usbpd_evq.sv -----
// usbpd_evq: two-entry event queue between front and back
// depends on usbpd_pkg for the event type
`timescale 1ns / 1ps
`default_nettype none
module usbpd_evq
  import usbpd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr,
  input  wire ev_t  wr_data,
  input  wire logic rd,
  output ev_t       rd_data,
  output logic      rd_valid,
  output logic      q_full
);

  ev_t        slot [2];
  logic [1:0] count;
  logic       rd_ptr, wr_ptr;

  assign rd_data  = slot[rd_ptr];
  assign rd_valid = (count != 2'd0);
  assign q_full   = (count == 2'd2);

  // storage
  always_ff @(posedge clk) begin
    if (wr) slot[wr_ptr] <= wr_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (wr) wr_ptr <= ~wr_ptr;
      if (rd) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, wr} - {1'b0, rd};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !wr || rd)
    else $error("write into full event queue");

endmodule
`default_nettype wire

// ----- hw/rtl/usbpd_back.sv -----
// usbpd_back: byte count, header capture, crc-32 and frame report
// depends on usbpd_pkg; drives the result register
`timescale 1ns / 1ps
`default_nettype none
module usbpd_back
  import usbpd_pkg::*;
#(
  parameter int PAYLOAD_BYTES = PayloadBytesDefault
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire ev_t        ev,
  input  wire logic       ev_valid,
  output logic            ev_take,
  input  wire logic [6:0] ack_target_mask,
  input  wire logic       pop,
  output logic            empty,
  output logic            item_kind,
  output logic [7:0]      payload_byte,
  output logic [2:0]      frame_target,
  output logic            crc_good,
  output logic [6:0]      frame_bytes,
  output logic            ack_request,
  output logic [2:0]      ack_message_id
);

  localparam logic [6:0] MaxBytes = 7'(PAYLOAD_BYTES);

  logic        out_valid;
  logic [6:0]  byte_cnt;
  logic [15:0] header;
  logic [31:0] crc;

  logic [6:0]  cnt_eff;
  logic [15:0] hdr_eff;
  logic [31:0] crc_eff;
  logic        keep_byte;
  logic        good;
  logic        ack;

  assign empty   = !out_valid;
  assign ev_take = ev_valid && (!out_valid || pop);

  // frame state as seen by this event
  always_comb begin
    cnt_eff   = ev.first ? 7'd0 : byte_cnt;
    hdr_eff   = ev.first ? 16'd0 : header;
    crc_eff   = ev.first ? 32'hFFFF_FFFF : crc;
    keep_byte = (ev.kind == EV_BYTE) && (cnt_eff < MaxBytes);
    good      = (cnt_eff > 7'd4) && (crc_eff == CRC_RESIDUE);
    ack       = good && ack_target_mask[ev.target] && hdr_eff[5] &&
                ((hdr_eff[14:12] != 3'd0) || (hdr_eff[4:0] != MTYPE_GOODCRC));
  end

  // frame accounting
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_cnt <= 7'd0;
      header   <= 16'd0;
      crc      <= 32'hFFFF_FFFF;
    end else if (ev_take) begin
      byte_cnt <= cnt_eff;
      header   <= hdr_eff;
      crc      <= crc_eff;
      if (keep_byte) begin
        byte_cnt <= cnt_eff + 7'd1;
        crc      <= crc_byte(crc_eff, ev.data);
        if (cnt_eff == 7'd0) header <= {8'd0, ev.data};
        else if (cnt_eff == 7'd1) header <= {ev.data, hdr_eff[7:0]};
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid) out_valid <= 1'b0;
      if (ev_take && (keep_byte || ev.kind == EV_EOP)) out_valid <= 1'b1;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (ev_take && (keep_byte || ev.kind == EV_EOP)) begin
      if (ev.kind == EV_BYTE) begin
        item_kind      <= 1'b0;
        payload_byte   <= ev.data;
        frame_target   <= 3'd0;
        crc_good       <= 1'b0;
        frame_bytes    <= 7'd0;
        ack_request    <= 1'b0;
        ack_message_id <= 3'd0;
      end else begin
        item_kind      <= 1'b1;
        payload_byte   <= 8'd0;
        frame_target   <= ev.target;
        crc_good       <= good;
        frame_bytes    <= cnt_eff;
        ack_request    <= ack;
        ack_message_id <= hdr_eff[11:9];
      end
    end
  end

  a_byte_cap: assert property (@(posedge clk) disable iff (rst)
    byte_cnt <= MaxBytes)
    else $error("byte count above capacity");

endmodule
`default_nettype wire

// ----- verif/tb_usb_pd_bmc_receiver.sv -----
// tb_usb_pd_bmc_receiver: self-checking testbench for the bmc / 4b5b receiver
// depends on usbpd_pkg and usb_pd_bmc_receiver; builds pulse trains of whole frames
`timescale 1ns / 1ps
module tb_usb_pd_bmc_receiver;
  import usbpd_pkg::*;

  localparam int MaxSym   = MaxSymbolsDefault;
  localparam int MaxBytes = PayloadBytesDefault;

  typedef enum logic [1:0] {RX_IDLE, RX_PREAMBLE, RX_SOP, RX_PAYLOAD} rx_phase_t;

  typedef struct packed {
    ev_kind_t   kind;
    logic [7:0] data;
    logic [2:0] target;
    logic       crc_ok;
    logic [6:0] nbytes;
    logic       ack;
    logic [2:0] msg_id;
  } rx_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [14:0] pulse_length = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        item_kind;
  logic [7:0]  payload_byte;
  logic [2:0]  frame_target;
  logic        crc_good;
  logic [6:0]  frame_bytes;
  logic        ack_request;
  logic [2:0]  ack_message_id;

  usb_pd_bmc_receiver i_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .pulse_length(pulse_length),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .empty(empty), .pop(pop), .item_kind(item_kind),
    .payload_byte(payload_byte), .frame_target(frame_target), .crc_good(crc_good),
    .frame_bytes(frame_bytes), .ack_request(ack_request), .ack_message_id(ack_message_id)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model configuration and frame state
  logic [7:0]  short_lim = 8'd16;
  logic [7:0]  long_lim  = 8'd24;
  logic [6:0]  ack_mask  = 7'd1;
  rx_phase_t   ph = RX_IDLE;
  logic        half_seen = 1'b0;
  int          adjust = 0;
  logic [4:0]  window = '0;
  logic [2:0]  bit_cnt = '0;
  logic [7:0]  sym_cnt = '0;
  logic [19:0] oset_acc = '0;
  logic [4:0]  lo_nib = '0;
  logic [31:0] crc_acc = '1;
  logic [6:0]  byte_cnt = '0;
  logic [15:0] header = '0;
  logic [2:0]  tgt_idx = '0;

  rx_item_t    expected_items[$];
  int          errors = 0;
  int          pulses_sent = 0;
  int          burst_left = 0;
  int          hold_cycles = 0;
  int          pulse_q[$];

  function automatic logic [4:0] line_to_sym(input logic [4:0] c);
    case (c)
      5'd6: return K_S3;   5'd7: return K_R1;   5'd9: return 5'd1;   5'd10: return 5'd4;
      5'd11: return 5'd5;  5'd13: return K_EOP; 5'd14: return 5'd6;  5'd15: return 5'd7;
      5'd17: return K_S2;  5'd18: return 5'd8;  5'd19: return 5'd9;  5'd20: return 5'd2;
      5'd21: return 5'd3;  5'd22: return 5'd10; 5'd23: return 5'd11; 5'd24: return K_S1;
      5'd25: return K_R2;  5'd26: return 5'd12; 5'd27: return 5'd13; 5'd28: return 5'd14;
      5'd29: return 5'd15; 5'd30: return 5'd0;
      default: return K_BAD;
    endcase
  endfunction

  function automatic logic [4:0] nibble_code(input logic [3:0] n);
    logic [4:0] codes [16];
    codes = '{5'd30, 5'd9, 5'd20, 5'd21, 5'd10, 5'd11, 5'd14, 5'd15,
              5'd18, 5'd19, 5'd22, 5'd23, 5'd26, 5'd27, 5'd28, 5'd29};
    return codes[n];
  endfunction

  // line codes of the four ordered-set symbols, first symbol in bits 4:0
  function automatic logic [19:0] sop_codes(input int t);
    case (t)
      0: return {5'd17, 5'd24, 5'd24, 5'd24};
      1: return {5'd6, 5'd6, 5'd24, 5'd24};
      2: return {5'd6, 5'd24, 5'd6, 5'd24};
      3: return {5'd6, 5'd25, 5'd25, 5'd24};
      4: return {5'd17, 5'd6, 5'd25, 5'd24};
      5: return {5'd25, 5'd7, 5'd7, 5'd7};
      default: return {5'd6, 5'd7, 5'd24, 5'd7};
    endcase
  endfunction

  function automatic logic [19:0] sop_symbols(input int t);
    logic [19:0] c;
    c = sop_codes(t);
    return {line_to_sym(c[19:15]), line_to_sym(c[14:10]),
            line_to_sym(c[9:5]), line_to_sym(c[4:0])};
  endfunction

  function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) r = r[0] ? ((r >> 1) ^ 32'hEDB88320) : (r >> 1);
    return r;
  endfunction

  function automatic void shift_bit(input logic b);
    window  = {b, window[4:1]};
    bit_cnt = bit_cnt + 3'd1;
  endfunction

  // advance the receiver model by one pulse
  function automatic bit decode_pulse(input logic [14:0] p, output rx_item_t r);
    logic       is_long;
    logic [4:0] s;
    logic [7:0] idx;
    logic [7:0] b;
    r = '0;
    if (p == 0) begin
      ph = RX_IDLE;
      return 0;
    end
    if (ph == RX_IDLE) begin
      half_seen = 0; adjust = 0; window = '0; bit_cnt = '0; sym_cnt = '0;
      oset_acc = '0; lo_nib = '0; crc_acc = '1; byte_cnt = '0; header = '0;
      tgt_idx = '0; ph = RX_PREAMBLE;
    end
    is_long = int'(p) > int'(long_lim) + adjust;
    if (!is_long && int'(p) > int'(short_lim)) adjust = int'(short_lim) - int'(p);
    else adjust = 0;
    if (half_seen) begin
      half_seen = 0;
      if (is_long) ph = RX_IDLE;
      else shift_bit(1'b1);
    end else if (is_long) begin
      shift_bit(1'b0);
    end else begin
      half_seen = 1;
    end
    if (ph == RX_PREAMBLE) begin
      s = line_to_sym(window);
      if (s == K_S1 || s == K_R1) begin
        ph = RX_SOP;
        bit_cnt = 3'd5;
      end
    end
    if (ph == RX_SOP && bit_cnt == 3'd5) begin
      bit_cnt = '0;
      s = line_to_sym(window);
      oset_acc = oset_acc | (20'(s) << (5 * sym_cnt[1:0]));
      sym_cnt = sym_cnt + 8'd1;
      if (sym_cnt >= 4) begin
        ph = RX_IDLE;
        for (int j = 0; j < NumTargets; j++) begin
          if (oset_acc == sop_symbols(j)) begin
            tgt_idx = 3'(j);
            ph = RX_PAYLOAD;
          end
        end
      end
      return 0;
    end
    if (ph == RX_PAYLOAD && bit_cnt == 3'd5) begin
      bit_cnt = '0;
      s = line_to_sym(window);
      if (sym_cnt < MaxSym) begin
        idx = sym_cnt;
        sym_cnt = sym_cnt + 8'd1;
        if (!idx[0]) begin
          lo_nib = {1'b1, s[3:0]};
        end else begin
          b = {s[3:0], lo_nib[3:0]};
          if (lo_nib[4] && s != K_EOP && int'(idx) + 1 < MaxSym && byte_cnt < MaxBytes) begin
            lo_nib = '0;
            if (byte_cnt == 0) header[7:0] = b;
            else if (byte_cnt == 1) header[15:8] = b;
            crc_acc = crc32_step(crc_acc, b);
            byte_cnt = byte_cnt + 7'd1;
            r.kind = EV_BYTE;
            r.data = b;
            return 1;
          end
          lo_nib = '0;
        end
      end
      if (s == K_EOP) begin
        r.kind   = EV_EOP;
        r.target = tgt_idx;
        r.crc_ok = byte_cnt > 4 && crc_acc == CRC_RESIDUE;
        r.nbytes = byte_cnt;
        r.ack    = r.crc_ok && ack_mask[tgt_idx] && header[5] &&
                   (header[14:12] != 0 || header[4:0] != MTYPE_GOODCRC);
        r.msg_id = header[11:9];
        ph = RX_IDLE;
        return 1;
      end
    end
    return 0;
  endfunction

  // send one pulse beat, bursts separated by random gaps
  task automatic send_pulse(input logic [14:0] p);
    rx_item_t r;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    push <= 1'b1;
    pulse_length <= p;
    @(posedge clk);
    while (full) @(posedge clk);
    pulses_sent++;
    if (decode_pulse(p, r)) expected_items.push_back(r);
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (expected_items.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SHORT_LIMIT: short_lim = v;
      CFG_LONG_LIMIT:  long_lim  = v;
      default:         ack_mask  = v[6:0];
    endcase
  endtask

  task automatic set_limits(input logic [7:0] s, input logic [7:0] l, input logic [6:0] m);
    write_reg(CFG_SHORT_LIMIT, s);
    write_reg(CFG_LONG_LIMIT, l);
    write_reg(CFG_ACK_MASK, {1'b0, m});
  endtask

  // bmc pulse shapes for the current thresholds
  function automatic void add_bit(input logic b);
    int smax;
    smax = (short_lim < long_lim) ? short_lim : long_lim;
    if (b) begin
      pulse_q.push_back($urandom_range(1, smax));
      pulse_q.push_back($urandom_range(1, smax));
    end else if ($urandom_range(0, 15) == 0) begin
      pulse_q.push_back($urandom_range(long_lim + 1, 32767));
    end else begin
      pulse_q.push_back($urandom_range(long_lim + 1, long_lim + 30));
    end
  endfunction

  function automatic void add_code(input logic [4:0] c);
    for (int i = 0; i < 5; i++) add_bit(c[i]);
  endfunction

  task automatic flush_pulses();
    while (pulse_q.size() != 0) send_pulse(15'(pulse_q.pop_front()));
  endtask

  // one frame: preamble, ordered set, payload with optional crc, eop
  task automatic send_frame(input int t, input int n, input bit with_crc,
                            input int hdr0, input bit bad_set, input int abort_at);
    logic [19:0] oc;
    logic [7:0]  bytes[$];
    logic [31:0] c;
    c = '1;
    for (int i = 0; i < n; i++) begin
      bytes.push_back((i == 0 && hdr0 >= 0) ? 8'(hdr0) : 8'($urandom));
      c = crc32_step(c, bytes[i]);
    end
    if (with_crc) begin
      c = ~c;
      for (int i = 0; i < 4; i++) bytes.push_back(c[8*i +: 8]);
    end
    for (int i = 0, k = $urandom_range(4, 16); i < k; i++) add_bit(i[0]);
    oc = sop_codes(t);
    if (bad_set) oc[19:15] = 5'd24;
    for (int i = 0; i < 4; i++) add_code(oc[5*i +: 5]);
    foreach (bytes[i]) begin
      if (i == abort_at) begin
        pulse_q.push_back(1);
        pulse_q.push_back(long_lim + 5);
      end
      add_code(nibble_code(bytes[i][3:0]));
      add_code(nibble_code(bytes[i][7:4]));
    end
    add_code(5'd13);
    if ($urandom_range(0, 1)) pulse_q.push_back(0);
    flush_pulses();
  endtask

  // result side: check every popped beat, stall on a randomly chosen pattern
  initial begin : result_check
    rx_item_t e;
    int mode;
    int cyc;
    mode = 0;
    cyc = 0;
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        if (expected_items.size() == 0) begin
          $display("%0t: unexpected result kind %0d byte %h", $time, item_kind, payload_byte);
          errors++;
        end else begin
          e = expected_items.pop_front();
          if (e != {ev_kind_t'(item_kind), payload_byte, frame_target, crc_good,
                    frame_bytes, ack_request, ack_message_id}) begin
            $display("%0t: expected kind %0d byte %h tgt %0d crc %0d n %0d ack %0d id %0d",
                     $time, e.kind, e.data, e.target, e.crc_ok, e.nbytes, e.ack, e.msg_id);
            $display("%0t: actual   kind %0d byte %h tgt %0d crc %0d n %0d ack %0d id %0d",
                     $time, item_kind, payload_byte, frame_target, crc_good, frame_bytes,
                     ack_request, ack_message_id);
            errors++;
          end
        end
      end
      cyc++;
      if (cyc % 97 == 0) mode = $urandom_range(0, 3);
      if (hold_cycles > 0) begin
        hold_cycles--;
        pop <= 1'b0;
      end else begin
        case (mode)
          0: pop <= 1'b1;
          1: pop <= ($urandom_range(0, 1) == 0);
          2: pop <= ($urandom_range(0, 3) == 0);
          default: pop <= (cyc % 5 != 0);
        endcase
      end
    end
  end

  task automatic test_defaults();
    send_frame(0, 2, 1, 8'h22, 0, -1);
    send_frame(0, 0, 1, 8'h21, 0, -1);
    send_frame(0, 0, 0, -1, 0, -1);
  endtask

  task automatic test_targets();
    set_limits(8'd16, 8'd24, 7'h7F);
    for (int t = 0; t < NumTargets; t++) send_frame(t, $urandom_range(0, 2), 0, 8'h23, 0, -1);
  endtask

  task automatic test_limit_extremes();
    set_limits(8'd1, 8'd1, 7'h00);
    send_frame(1, 1, 1, 8'h20, 0, -1);
    set_limits(8'd255, 8'd255, 7'h55);
    send_frame(2, 1, 1, 8'h24, 0, -1);
    set_limits(8'd40, 8'd10, 7'h2A);
    send_frame(3, 1, 1, 8'h2F, 0, -1);
    set_limits(8'd16, 8'd24, 7'h01);
  endtask

  task automatic test_aborts();
    // lone short then long, unknown ordered set, zero pulse inside a frame
    send_frame(0, 2, 1, 8'h22, 0, 3);
    send_frame(5, 0, 0, -1, 1, -1);
    for (int i = 0; i < 10; i++) add_bit(i[0]);
    add_code(5'd24);
    pulse_q.push_back(0);
    flush_pulses();
    // short pulses above nominal tighten the next threshold
    for (int i = 0; i < 8; i++) begin
      send_pulse(15'(short_lim + $urandom_range(1, 8)));
      send_pulse(15'(long_lim + $urandom_range(0, 4)));
    end
    send_pulse(15'h7FFF);
    send_pulse(15'd0);
  endtask

  task automatic test_overflow();
    send_frame(4, 62, 1, 8'h22, 0, -1);
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    send_frame(0, 8, 1, 8'h22, 0, -1);
  endtask

  task automatic test_random();
    int sel;
    while (pulses_sent < 3000) begin
      sel = $urandom_range(0, 99);
      if (sel < 4) begin
        set_limits(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                   7'($urandom_range(0, 127)));
      end else if (sel < 8) begin
        set_limits(8'($urandom_range(8, 24)), 8'($urandom_range(20, 40)),
                   7'($urandom_range(0, 127)));
      end else if (sel < 20) begin
        for (int i = 0, k = $urandom_range(5, 30); i < k; i++) begin
          if ($urandom_range(0, 1)) send_pulse(15'($urandom));
          else send_pulse(15'($urandom_range(0, 60)));
        end
      end else if (sel < 23) begin
        send_frame($urandom_range(0, 6), $urandom_range(60, 70), $urandom_range(0, 1),
                   -1, 0, -1);
      end else begin
        send_frame($urandom_range(0, 6), $urandom_range(0, 12), $urandom_range(0, 3) != 0,
                   ($urandom_range(0, 1)) ? -1 : (8'h20 | $urandom_range(0, 3)),
                   $urandom_range(0, 15) == 0,
                   ($urandom_range(0, 15) == 0) ? $urandom_range(0, 6) : -1);
      end
    end
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_targets();
    test_limit_extremes();
    test_aborts();
    test_overflow();
    test_backpressure();
    test_random();
    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin : watchdog
    #30ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/usbpd_pkg.sv
hw/rtl/usbpd_front.sv
hw/rtl/usbpd_evq.sv
hw/rtl/usbpd_back.sv
hw/rtl/usb_pd_bmc_receiver.sv
verif/tb_usb_pd_bmc_receiver.sv
